// ----- rtl/core/uhlfr_pkg.sv -----
// shared types and constants for the header and length frame receiver
package uhlfr_pkg;

  localparam int unsigned StoreDepthDefault = 1024;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned RdAddrW  = 10;
  localparam int unsigned CountW   = 11;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned TotalW   = 17;
  localparam int unsigned CfgIdxW  = 2;

  // frame layout
  localparam int unsigned HeaderLen   = 3;
  localparam int unsigned ExtLowPos   = 10;
  localparam int unsigned ExtHighPos  = 11;
  localparam int unsigned ExtOverhead = 13;

  // register reset values
  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'd126;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'd85;
  localparam logic [ByteW-1:0] MinLengthRst    = 8'd3;
  localparam logic [ByteW-1:0] MaxLengthRst    = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeaderFirst  = 2'd0,
    CfgHeaderSecond = 2'd1,
    CfgMinLength    = 2'd2,
    CfgMaxLength    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ActReceive = 2'd0,
    ActTimeout = 2'd1,
    ActRelease = 2'd2,
    ActRead    = 2'd3
  } action_e;

endpackage

// ----- rtl/core/uhlfr_store.sv -----
// frame byte store, one write port and one registered read port
module uhlfr_store #(
  parameter int unsigned Depth = uhlfr_pkg::StoreDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(Depth)-1:0]      wr_addr_i,
  input  logic [uhlfr_pkg::ByteW-1:0]   wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(Depth)-1:0]      rd_addr_i,
  output logic [uhlfr_pkg::ByteW-1:0]   rd_data_o
);
  import uhlfr_pkg::*;

  logic [ByteW-1:0] mem [Depth];
  logic [ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/uart_header_length_frame_receiver.sv -----
// top level of the header and length prefixed frame receiver
// Takes one word per cycle and returns one result word per input word. Each
// word carries an action: receive a uart byte, signal a line timeout,
// release a waiting frame, or read a byte of the frame store. The receiver
// hunts for header_first then header_second, takes a length byte in
// [min_length, max_length] for a frame of length + 3 bytes, or a zero length
// byte for an extended frame whose 16-bit little-endian count sits at byte
// positions 10 and 11 (total count + 13, dropped if it exceeds the store).
// The result reports phase, bytes stored and, for a read, the store byte
// (zero for an address past the store). Throughput is one word per clock:
// the phase, count and length registers update in one pass per word, and
// the store takes at most one write or one registered read per word. The
// phase and count registers double as the result register, so a new word
// is taken whenever the result slot is empty or being drained. The store
// needs no clearing after reset; reading a byte never written since reset
// returns an unspecified value. Configuration must be written only while
// no word is in flight; the block itself does not enforce this.
module uart_header_length_frame_receiver #(
  parameter int unsigned StoreDepth = uhlfr_pkg::StoreDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [uhlfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uhlfr_pkg::ByteW-1:0]    cfg_wdata_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic [uhlfr_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [uhlfr_pkg::RdAddrW-1:0]  read_address_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           frame_ready_o,
  output logic [uhlfr_pkg::PhaseW-1:0]   phase_code_o,
  output logic [uhlfr_pkg::CountW-1:0]   frame_count_o,
  output logic [uhlfr_pkg::ByteW-1:0]    read_data_o
);
  import uhlfr_pkg::*;

  // store address width and a byte count wide enough for the full store
  localparam int unsigned AddrW  = $clog2(StoreDepth);
  localparam int unsigned DepthW = $clog2(StoreDepth + 1);
  localparam int unsigned CntW   = (DepthW > CountW) ? DepthW : CountW;

  localparam logic [CntW-1:0]   DepthCnt   = CntW'(StoreDepth);
  localparam logic [TotalW-1:0] DepthTotal = TotalW'(StoreDepth);

  typedef enum logic [PhaseW-1:0] {
    PhIdle    = 3'd0,
    PhHead1   = 3'd1,
    PhHead2   = 3'd2,
    PhData    = 3'd3,
    PhEnd     = 3'd4,
    PhTimeout = 3'd5
  } phase_e;

  // configuration registers
  logic [ByteW-1:0] hdr_first_q, hdr_second_q, min_len_q, max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
      min_len_q    <= MinLengthRst;
      max_len_q    <= MaxLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgHeaderFirst:  hdr_first_q  <= cfg_wdata_i;
        CfgHeaderSecond: hdr_second_q <= cfg_wdata_i;
        CfgMinLength:    min_len_q    <= cfg_wdata_i;
        CfgMaxLength:    max_len_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // receiver state, also the result register
  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [ByteW-1:0]  ext_low_q, ext_low_d;
  logic              out_valid_q, out_valid_d;
  logic              rd_sel_q, rd_sel_d;

  logic              accept;
  logic              wr_en;
  logic              rd_en;
  logic [CntW-1:0]   cnt_inc;
  logic [TotalW-1:0] ext_total;
  logic              len_in_range;
  logic              rd_in_range;
  logic [TotalW-1:0] rd_addr_ext;

  // result slot is free when empty or being drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cnt_inc      = cnt_q + CntW'(1);
  assign ext_total    = TotalW'({rx_byte_i, ext_low_q}) + TotalW'(ExtOverhead);
  assign len_in_range = (rx_byte_i >= min_len_q) && (rx_byte_i <= max_len_q);
  assign rd_addr_ext  = TotalW'(read_address_i);
  assign rd_in_range  = rd_addr_ext < DepthTotal;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    ext_low_d   = ext_low_q;
    rd_sel_d    = rd_sel_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_valid_d = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      out_valid_d = 1'b1;
      rd_sel_d    = 1'b0;
      case (action_e'(action_i))
        ActReceive: begin
          case (phase_q)
            PhIdle: begin
              if (rx_byte_i == hdr_first_q) begin
                phase_d = PhHead1;
                wr_en   = 1'b1;
                cnt_d   = CntW'(1);
              end
            end
            PhHead1: begin
              if (rx_byte_i == hdr_second_q) begin
                phase_d = PhHead2;
                wr_en   = 1'b1;
                cnt_d   = CntW'(2);
              end else if (rx_byte_i == hdr_first_q) begin
                // repeated first header byte keeps hunting
                cnt_d = CntW'(1);
              end else begin
                phase_d = PhIdle;
                cnt_d   = '0;
              end
            end
            PhHead2: begin
              // range test wins over the zero length test
              if (len_in_range) begin
                phase_d = PhData;
                total_d = TotalW'(rx_byte_i) + TotalW'(HeaderLen);
                wr_en   = 1'b1;
                cnt_d   = CntW'(HeaderLen);
              end else if (rx_byte_i == '0) begin
                phase_d = PhData;
                total_d = '0;
                wr_en   = 1'b1;
                cnt_d   = CntW'(HeaderLen);
              end else begin
                phase_d = PhIdle;
                cnt_d   = '0;
              end
            end
            PhData: begin
              if (cnt_q >= DepthCnt) begin
                phase_d = PhIdle;
                cnt_d   = '0;
              end else begin
                wr_en = 1'b1;
                cnt_d = cnt_inc;
                if (total_q == '0) begin
                  // extended length: count bytes arrive in the payload
                  if (cnt_inc == CntW'(ExtLowPos)) begin
                    ext_low_d = rx_byte_i;
                  end else if (cnt_inc == CntW'(ExtHighPos)) begin
                    total_d = ext_total;
                    if (ext_total > DepthTotal) begin
                      phase_d = PhIdle;
                      cnt_d   = '0;
                    end
                  end
                end else if (TotalW'(cnt_inc) >= total_q) begin
                  phase_d = PhEnd;
                end
              end
            end
            default: ;
          endcase
        end
        ActTimeout: begin
          if (phase_q inside {PhHead1, PhHead2, PhData, PhTimeout}) begin
            // short frames are dropped, longer ones wait for release
            if (cnt_q <= CntW'(min_len_q)) begin
              phase_d = PhIdle;
              cnt_d   = '0;
            end else begin
              phase_d = PhTimeout;
            end
          end
        end
        ActRelease: begin
          phase_d = PhIdle;
          cnt_d   = '0;
          total_d = '0;
        end
        ActRead: begin
          rd_en    = rd_in_range;
          rd_sel_d = rd_in_range;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      cnt_q       <= '0;
      total_q     <= '0;
      ext_low_q   <= '0;
      out_valid_q <= 1'b0;
      rd_sel_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      ext_low_q   <= ext_low_d;
      out_valid_q <= out_valid_d;
      rd_sel_q    <= rd_sel_d;
    end
  end

  logic [ByteW-1:0] store_rd_data;

  uhlfr_store #(
    .Depth (StoreDepth)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_ext[AddrW-1:0]),
    .rd_data_o (store_rd_data)
  );

  // result word
  assign out_valid_o   = out_valid_q;
  assign frame_ready_o = phase_q inside {PhEnd, PhTimeout};
  assign phase_code_o  = phase_q;
  assign frame_count_o = cnt_q[CountW-1:0];
  assign read_data_o   = rd_sel_q ? store_rd_data : '0;

`ifndef SYNTH
  // idle always comes with an empty frame
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> cnt_q == '0)
    else $error("idle phase with nonzero byte count");

  // header phases hold exactly the header bytes seen
  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHead1 |-> cnt_q == CntW'(1)) and
    (phase_q == PhHead2 |-> cnt_q == CntW'(2)))
    else $error("header phase with wrong byte count");

  // data phase never runs past the store
  a_data_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> (cnt_q >= CntW'(HeaderLen)) && (cnt_q < DepthCnt))
    else $error("data phase byte count out of range");

  // bytes arriving while a complete frame waits are ignored
  a_end_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ActReceive && phase_q == PhEnd |=>
      $stable(cnt_q) && phase_q == PhEnd)
    else $error("waiting frame changed by received byte");

  // store is never written or read unless a word is taken
  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en || rd_en) |-> accept)
    else $error("store access without an accepted word");
`endif

endmodule
